// ===== hw/rtl/rfvb_pkg.sv =====
// shared types, codes and defaults for the replica fifo with vc binding
package rfvb_pkg;

  // default sizes
  localparam int FIFO_DEPTH_DEF   = 16;
  localparam int BIND_ENTRIES_DEF = 16;

  // field widths
  localparam int MODE_W   = 2;
  localparam int PID_W    = 16;
  localparam int KIND_W   = 2;
  localparam int PORT_W   = 3;
  localparam int HANDLE_W = 32;
  localparam int VC_W     = 4;
  localparam int STATUS_W = 3;

  // request modes
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GRANT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd3;

  // flit kinds
  localparam logic [KIND_W-1:0] KIND_HEAD      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BODY      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TAIL      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HEAD_TAIL = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONHEAD  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd5;

  // one buffered replica
  typedef struct packed {
    logic [PID_W-1:0]    pid;
    logic [KIND_W-1:0]   kind;
    logic [PORT_W-1:0]   port;
    logic [HANDLE_W-1:0] handle;
  } rfvb_entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;   // capture accepted request
    logic push;    // write entry store on push
    logic read;    // read front entry
    logic match;   // compare front key against binding table
    logic commit;  // update table and pointers, load result
  } rfvb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;  // result register still holds an untaken result
  } rfvb_sts_t;

endpackage

// ===== hw/rtl/rfvb_ctrl.sv =====
// sequencing state machine for the replica fifo with vc binding
module rfvb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rfvb_pkg::rfvb_sts_t sts,
  output rfvb_pkg::rfvb_cmd_t cmd
);
  import rfvb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_READ  = 5'b00100,
    S_MATCH = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.push   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_MATCH;
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // a result is only loaded into a free output register
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !sts.out_busy) else $error("commit while output busy");

  // an accepted request runs its execute step next
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (cmd.push && !in_ready))
    else $error("accepted request did not start");

  // no new request while one is in flight
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> !in_ready) else $error("ready raised mid request");

endmodule

// ===== hw/rtl/rfvb_dp.sv =====
// datapath: entry store, pointers, binding table and result register
module rfvb_dp #(
  parameter int FIFO_DEPTH   = rfvb_pkg::FIFO_DEPTH_DEF,
  parameter int BIND_ENTRIES = rfvb_pkg::BIND_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rfvb_pkg::rfvb_cmd_t             cmd,
  output rfvb_pkg::rfvb_sts_t             sts,
  input  logic [rfvb_pkg::MODE_W-1:0]     mode,
  input  logic [rfvb_pkg::PID_W-1:0]      packet_id,
  input  logic [rfvb_pkg::KIND_W-1:0]     flit_kind,
  input  logic [rfvb_pkg::PORT_W-1:0]     out_port,
  input  logic [rfvb_pkg::HANDLE_W-1:0]   flit_handle,
  input  logic [rfvb_pkg::VC_W-1:0]       grant_vc,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            front_valid,
  output logic [rfvb_pkg::PID_W-1:0]      front_packet_id,
  output logic [rfvb_pkg::KIND_W-1:0]     front_kind,
  output logic [rfvb_pkg::PORT_W-1:0]     front_port,
  output logic [rfvb_pkg::HANDLE_W-1:0]   front_handle,
  output logic                            vc_bound,
  output logic [rfvb_pkg::VC_W-1:0]       front_vc,
  output logic [rfvb_pkg::STATUS_W-1:0]   status
);
  import rfvb_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // captured request
  logic [MODE_W-1:0] op_mode;
  rfvb_entry_t       op_entry;
  logic [VC_W-1:0]   op_vc;
  logic              op_full;
  logic              op_empty;

  // fifo state
  rfvb_entry_t      mem [FIFO_DEPTH];
  rfvb_entry_t      rd_q;
  logic [PTR_W-1:0] rp;
  logic [PTR_W-1:0] wp;
  logic [CNT_W-1:0] count;

  // binding table
  logic [BIND_ENTRIES-1:0] bind_valid;
  logic [PID_W-1:0]        bind_pid  [BIND_ENTRIES];
  logic [PORT_W-1:0]       bind_port [BIND_ENTRIES];
  logic [VC_W-1:0]         bind_vc   [BIND_ENTRIES];
  logic [BIND_ENTRIES-1:0] match_q;
  logic [BIND_ENTRIES-1:0] free_q;

  // commit-time decode
  logic              is_head;
  logic              is_tail;
  logic              hit;
  logic [VC_W-1:0]   hit_vc;
  logic              do_grant;
  logic              do_unbind;
  logic              do_pop;
  logic [STATUS_W-1:0] res_status;
  logic              res_valid;
  logic              res_bound;
  logic [VC_W-1:0]   res_vc;

  assign sts.out_busy = out_valid && !out_ready;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_mode         <= mode;
      op_entry.pid    <= packet_id;
      op_entry.kind   <= flit_kind;
      op_entry.port   <= out_port;
      op_entry.handle <= flit_handle;
      op_vc           <= grant_vc;
      op_full         <= (count == CNT_FULL);
      op_empty        <= (count == '0);
    end
  end

  // entry store write and registered front read
  always_ff @(posedge clk) begin
    if (cmd.push && op_mode == MODE_PUSH && !op_full) mem[wp] <= op_entry;
    if (cmd.read) rd_q <= mem[rp];
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rp    <= '0;
      wp    <= '0;
      count <= '0;
    end else begin
      if (cmd.push && op_mode == MODE_PUSH && !op_full) begin
        wp    <= (wp == PTR_LAST) ? '0 : wp + 1'b1;
        count <= count + 1'b1;
      end
      if (do_pop) begin
        rp    <= (rp == PTR_LAST) ? '0 : rp + 1'b1;
        count <= count - 1'b1;
      end
    end
  end

  // key compare and lowest free slot
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < BIND_ENTRIES; i++) begin
        match_q[i] <= bind_valid[i] && bind_pid[i] == rd_q.pid &&
                      bind_port[i] == rd_q.port;
      end
      free_q <= ~bind_valid & (bind_valid + BIND_ENTRIES'(1));
    end
  end

  // matched channel, at most one slot matches
  always_comb begin
    hit_vc = '0;
    for (int i = 0; i < BIND_ENTRIES; i++) begin
      hit_vc = hit_vc | (bind_vc[i] & {VC_W{match_q[i]}});
    end
  end

  assign hit     = |match_q;
  assign is_head = (rd_q.kind == KIND_HEAD) || (rd_q.kind == KIND_HEAD_TAIL);
  assign is_tail = (rd_q.kind == KIND_TAIL) || (rd_q.kind == KIND_HEAD_TAIL);

  // result and table update decisions
  always_comb begin
    res_status = ST_OK;
    res_valid  = 1'b1;
    res_bound  = hit;
    res_vc     = hit_vc;
    do_grant   = 1'b0;
    do_unbind  = 1'b0;
    do_pop     = 1'b0;
    if (op_mode != MODE_PUSH && op_empty) begin
      res_status = ST_EMPTY;
      res_valid  = 1'b0;
      res_bound  = 1'b0;
      res_vc     = '0;
    end else begin
      case (op_mode)
        MODE_PUSH: begin
          if (op_full) res_status = ST_FULL;
        end
        MODE_QUERY: begin
          if (!is_head && !hit) res_status = ST_MISSING;
        end
        MODE_GRANT: begin
          if (!is_head) begin
            res_status = ST_NONHEAD;
          end else if (hit || free_q == '0) begin
            res_status = ST_CONFLICT;
          end else begin
            do_grant  = cmd.commit;
            res_bound = 1'b1;
            res_vc    = op_vc;
          end
        end
        MODE_POP: begin
          do_pop = cmd.commit;
          if (is_tail && !hit) res_status = ST_MISSING;
          if (is_tail) do_unbind = cmd.commit;
        end
        default: res_status = ST_OK;
      endcase
    end
  end

  // binding table valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      bind_valid <= '0;
    end else if (do_grant) begin
      bind_valid <= bind_valid | free_q;
    end else if (do_unbind) begin
      bind_valid <= bind_valid & ~match_q;
    end
  end

  // binding table payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < BIND_ENTRIES; i++) begin
      if (do_grant && free_q[i]) begin
        bind_pid[i]  <= rd_q.pid;
        bind_port[i] <= rd_q.port;
        bind_vc[i]   <= op_vc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      front_valid     <= res_valid;
      front_packet_id <= res_valid ? rd_q.pid    : '0;
      front_kind      <= res_valid ? rd_q.kind   : '0;
      front_port      <= res_valid ? rd_q.port   : '0;
      front_handle    <= res_valid ? rd_q.handle : '0;
      vc_bound        <= res_bound;
      front_vc        <= res_vc;
      status          <= res_status;
    end
  end

  // fill count never passes the depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL) else $error("fifo count overflow");

  // keys in the binding table are unique
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> $onehot0(match_q)) else $error("duplicate binding key");

  // a grant takes exactly one free slot
  a_grant_slot: assert property (@(posedge clk) disable iff (rst)
    do_grant |-> $onehot(free_q)) else $error("grant without single free slot");

  // a pop never happens on an empty buffer
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    do_pop |-> (count != '0)) else $error("pop on empty fifo");

endmodule

// ===== hw/rtl/replica_fifo_with_vc_binding_core.sv =====
// top level of the replica fifo with output vc binding
//
// Input channel (in_valid/in_ready) carries one request per item: mode
// selects push, query front, grant vc to a head front, or pop front, with
// packet_id, flit_kind, out_port and flit_handle used by push and grant_vc
// by grant. Output channel (out_valid/out_ready) returns exactly one result
// per request: the front entry (or the popped entry on pop), its binding
// and a status code.
//
// Each accepted request runs execute (store write), entry store read,
// parallel key compare over the binding table, then commit, which loads
// the result register and raises out_valid. in_ready is high only while
// no request is in flight, so a new request is accepted only after the previous one has committed.
//
// A finished result sits in the output register; the next request is
// accepted while it waits, and that request stalls at commit until the
// receiver takes the pending result. Reset empties the fifo and clears
// every binding valid bit at once; the entry store itself is not cleared.
module replica_fifo_with_vc_binding_core #(
  parameter int FIFO_DEPTH   = rfvb_pkg::FIFO_DEPTH_DEF,
  parameter int BIND_ENTRIES = rfvb_pkg::BIND_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rfvb_pkg::MODE_W-1:0]     mode,
  input  logic [rfvb_pkg::PID_W-1:0]      packet_id,
  input  logic [rfvb_pkg::KIND_W-1:0]     flit_kind,
  input  logic [rfvb_pkg::PORT_W-1:0]     out_port,
  input  logic [rfvb_pkg::HANDLE_W-1:0]   flit_handle,
  input  logic [rfvb_pkg::VC_W-1:0]       grant_vc,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            front_valid,
  output logic [rfvb_pkg::PID_W-1:0]      front_packet_id,
  output logic [rfvb_pkg::KIND_W-1:0]     front_kind,
  output logic [rfvb_pkg::PORT_W-1:0]     front_port,
  output logic [rfvb_pkg::HANDLE_W-1:0]   front_handle,
  output logic                            vc_bound,
  output logic [rfvb_pkg::VC_W-1:0]       front_vc,
  output logic [rfvb_pkg::STATUS_W-1:0]   status
);
  import rfvb_pkg::*;

  rfvb_cmd_t cmd;
  rfvb_sts_t sts;

  // sequencer
  rfvb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and result datapath
  rfvb_dp #(
    .FIFO_DEPTH   (FIFO_DEPTH),
    .BIND_ENTRIES (BIND_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .mode            (mode),
    .packet_id       (packet_id),
    .flit_kind       (flit_kind),
    .out_port        (out_port),
    .flit_handle     (flit_handle),
    .grant_vc        (grant_vc),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .front_valid     (front_valid),
    .front_packet_id (front_packet_id),
    .front_kind      (front_kind),
    .front_port      (front_port),
    .front_handle    (front_handle),
    .vc_bound        (vc_bound),
    .front_vc        (front_vc),
    .status          (status)
  );

endmodule

// ===== verif/replica_fifo_with_vc_binding_core_test.sv =====
// self-checking testbench for the replica fifo with output vc binding
module replica_fifo_with_vc_binding_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rfvb_pkg::*;

  localparam int DEPTH          = FIFO_DEPTH_DEF;
  localparam int BIND_SLOTS     = BIND_ENTRIES_DEF;
  localparam int NO_BINDING     = -1;
  localparam int RANDOM_ITEMS   = 1110;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RING_SLOTS     = 8;

  // one result as the block should report it
  typedef struct {
    logic                front_valid;
    logic [PID_W-1:0]    pid;
    logic [KIND_W-1:0]   kind;
    logic [PORT_W-1:0]   port;
    logic [HANDLE_W-1:0] handle;
    logic                vc_bound;
    logic [VC_W-1:0]     vc;
    logic [STATUS_W-1:0] status;
  } front_report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   mode = MODE_QUERY;
  logic [PID_W-1:0]    packet_id = '0;
  logic [KIND_W-1:0]   flit_kind = KIND_HEAD;
  logic [PORT_W-1:0]   out_port = '0;
  logic [HANDLE_W-1:0] flit_handle = '0;
  logic [VC_W-1:0]     grant_vc = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                front_valid;
  logic [PID_W-1:0]    front_packet_id;
  logic [KIND_W-1:0]   front_kind;
  logic [PORT_W-1:0]   front_port;
  logic [HANDLE_W-1:0] front_handle;
  logic                vc_bound;
  logic [VC_W-1:0]     front_vc;
  logic [STATUS_W-1:0] status;

  // shadow of the buffer and the binding table
  rfvb_entry_t      fifo_mem [DEPTH];
  int unsigned      rd_ptr = 0;
  int unsigned      wr_ptr = 0;
  int unsigned      fill = 0;
  logic             bind_vld [BIND_SLOTS] = '{default: 1'b0};
  logic [PID_W-1:0] bind_pid [BIND_SLOTS];
  logic [PORT_W-1:0] bind_port [BIND_SLOTS];
  logic [VC_W-1:0]  bind_vc [BIND_SLOTS];

  // expected reports in request order, indexed by request and result counts
  front_report_t want_ring [RING_SLOTS];
  int            fail_count = 0;
  int            req_count = 0;
  int            resp_count = 0;
  int            quiet_cycles = 0;
  logic          calm = 1'b0;

  replica_fifo_with_vc_binding_core #(
    .FIFO_DEPTH  (DEPTH),
    .BIND_ENTRIES(BIND_SLOTS)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .packet_id      (packet_id),
    .flit_kind      (flit_kind),
    .out_port       (out_port),
    .flit_handle    (flit_handle),
    .grant_vc       (grant_vc),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .front_valid    (front_valid),
    .front_packet_id(front_packet_id),
    .front_kind     (front_kind),
    .front_port     (front_port),
    .front_handle   (front_handle),
    .vc_bound       (vc_bound),
    .front_vc       (front_vc),
    .status         (status)
  );

  always #10 clk = ~clk;

  function automatic logic is_head(logic [KIND_W-1:0] kind);
    return kind == KIND_HEAD || kind == KIND_HEAD_TAIL;
  endfunction

  function automatic logic is_tail(logic [KIND_W-1:0] kind);
    return kind == KIND_TAIL || kind == KIND_HEAD_TAIL;
  endfunction

  function automatic int find_binding(logic [PID_W-1:0] pid, logic [PORT_W-1:0] port);
    for (int s = 0; s < BIND_SLOTS; s++) begin
      if (bind_vld[s] && bind_pid[s] == pid && bind_port[s] == port) return s;
    end
    return NO_BINDING;
  endfunction

  // report of an entry together with its current binding
  function automatic front_report_t report_entry(rfvb_entry_t e, logic [STATUS_W-1:0] st);
    front_report_t r;
    int slot;
    slot = find_binding(e.pid, e.port);
    r.front_valid = 1'b1;
    r.pid         = e.pid;
    r.kind        = e.kind;
    r.port        = e.port;
    r.handle      = e.handle;
    r.vc_bound    = (slot != NO_BINDING);
    r.vc          = (slot != NO_BINDING) ? bind_vc[slot] : '0;
    r.status      = st;
    return r;
  endfunction

  function automatic front_report_t empty_report(logic [STATUS_W-1:0] st);
    front_report_t r;
    r = '{default: '0};
    r.status = st;
    return r;
  endfunction

  // apply one request to the shadow state and return the expected report
  function automatic front_report_t predict_request(
    logic [MODE_W-1:0] op, logic [PID_W-1:0] pid, logic [KIND_W-1:0] kind,
    logic [PORT_W-1:0] port, logic [HANDLE_W-1:0] handle, logic [VC_W-1:0] vc);
    rfvb_entry_t         front;
    front_report_t       r;
    logic [STATUS_W-1:0] st;
    int                  slot;
    st = ST_OK;
    if (op == MODE_PUSH) begin
      if (fill >= DEPTH) begin
        st = ST_FULL;
      end else begin
        fifo_mem[wr_ptr].pid    = pid;
        fifo_mem[wr_ptr].kind   = kind;
        fifo_mem[wr_ptr].port   = port;
        fifo_mem[wr_ptr].handle = handle;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        fill++;
      end
      if (fill == 0) return empty_report(st);
      return report_entry(fifo_mem[rd_ptr], st);
    end
    if (fill == 0) return empty_report(ST_EMPTY);
    front = fifo_mem[rd_ptr];
    slot  = find_binding(front.pid, front.port);
    case (op)
      MODE_QUERY: begin
        if (!is_head(front.kind) && slot == NO_BINDING) st = ST_MISSING;
        return report_entry(front, st);
      end
      MODE_GRANT: begin
        if (!is_head(front.kind)) begin
          st = ST_NONHEAD;
        end else begin
          // lowest free slot wins, conflict if bound already or no slot left
          st = ST_CONFLICT;
          if (slot == NO_BINDING) begin
            for (int s = 0; s < BIND_SLOTS; s++) begin
              if (!bind_vld[s] && st == ST_CONFLICT) begin
                bind_vld[s]  = 1'b1;
                bind_pid[s]  = front.pid;
                bind_port[s] = front.port;
                bind_vc[s]   = vc;
                st = ST_OK;
              end
            end
          end
        end
        return report_entry(front, st);
      end
      default: begin
        // pop reports the binding as it was before a tail releases it
        if (is_tail(front.kind) && slot == NO_BINDING) st = ST_MISSING;
        r = report_entry(front, st);
        if (is_tail(front.kind) && slot != NO_BINDING) bind_vld[slot] = 1'b0;
        rd_ptr = (rd_ptr + 1) % DEPTH;
        fill--;
        return r;
      end
    endcase
  endfunction

  // drive one request, hold it until accepted, then record its expected report
  task automatic send_req(
    logic [MODE_W-1:0] op, logic [PID_W-1:0] pid, logic [KIND_W-1:0] kind,
    logic [PORT_W-1:0] port, logic [HANDLE_W-1:0] handle, logic [VC_W-1:0] vc);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= op;
    packet_id   <= pid;
    flit_kind   <= kind;
    out_port    <= port;
    flit_handle <= handle;
    grant_vc    <= vc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want_ring[req_count % RING_SLOTS] = predict_request(op, pid, kind, port, handle, vc);
    req_count++;
  endtask

  task automatic push_flit(logic [PID_W-1:0] pid, logic [KIND_W-1:0] kind,
                           logic [PORT_W-1:0] port, logic [HANDLE_W-1:0] handle);
    send_req(MODE_PUSH, pid, kind, port, handle, 4'($urandom));
  endtask

  // query, grant or pop; push-only fields carry random junk
  task automatic front_op(logic [MODE_W-1:0] op, logic [VC_W-1:0] vc);
    send_req(op, 16'($urandom), 2'($urandom), 3'($urandom), $urandom, vc);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (resp_count != req_count);
  endtask

  // small pool of ids so that keys collide, otherwise fully random
  function automatic logic [PID_W-1:0] pick_pid();
    if ($urandom_range(1) == 0) return 16'($urandom_range(7));
    return 16'($urandom);
  endfunction

  // every operation and every status code but ST_FULL
  task automatic test_directed_cases();
    front_op(MODE_POP, 4'd0);
    front_op(MODE_QUERY, 4'd0);
    front_op(MODE_GRANT, 4'd15);
    push_flit(16'hFFFF, KIND_HEAD, 3'd7, 32'hFFFF_FFFF);
    front_op(MODE_QUERY, 4'd0);
    front_op(MODE_GRANT, 4'd15);
    front_op(MODE_GRANT, 4'd3);
    push_flit(16'hFFFF, KIND_BODY, 3'd7, 32'h0);
    push_flit(16'hFFFF, KIND_TAIL, 3'd7, 32'hA5A5_5A5A);
    front_op(MODE_POP, 4'd0);
    front_op(MODE_GRANT, 4'd1);
    front_op(MODE_QUERY, 4'd0);
    front_op(MODE_POP, 4'd0);
    front_op(MODE_POP, 4'd0);
    push_flit(16'h0, KIND_BODY, 3'd0, 32'h0);
    front_op(MODE_QUERY, 4'd0);
    front_op(MODE_POP, 4'd0);
    push_flit(16'h0, KIND_HEAD_TAIL, 3'd0, 32'hFFFF_FFFF);
    front_op(MODE_GRANT, 4'd0);
    front_op(MODE_POP, 4'd0);
    push_flit(16'h0, KIND_TAIL, 3'd0, 32'h1234_5678);
    front_op(MODE_POP, 4'd0);
  endtask

  // fill the buffer, push once more while full, then drain it
  task automatic test_fifo_full();
    while (fill < DEPTH) push_flit(pick_pid(), 2'($urandom), 3'($urandom), $urandom);
    push_flit(16'hFFFF, KIND_HEAD, 3'd7, 32'hFFFF_FFFF);
    front_op(MODE_QUERY, 4'd0);
    while (fill > 0) front_op(MODE_POP, 4'd0);
  endtask

  // occupy every binding slot, grant once more, then release them all
  task automatic test_binding_table_full();
    for (int i = 0; i < BIND_SLOTS; i++) begin
      push_flit(16'h8000 | 16'(i), KIND_HEAD, 3'(i), $urandom);
      front_op(MODE_GRANT, 4'(i));
      front_op(MODE_POP, 4'd0);
    end
    push_flit(16'h9000, KIND_HEAD, 3'd5, $urandom);
    front_op(MODE_GRANT, 4'd7);
    front_op(MODE_POP, 4'd0);
    for (int i = 0; i < BIND_SLOTS; i++) begin
      push_flit(16'h8000 | 16'(i), KIND_TAIL, 3'(i), $urandom);
      front_op(MODE_POP, 4'd0);
    end
  endtask

  // handle the front the way a router would: usually grant an unbound head, sometimes query, then pop
  task automatic serve_front();
    rfvb_entry_t front;
    if (fill == 0) return;
    front = fifo_mem[rd_ptr];
    if (is_head(front.kind) && find_binding(front.pid, front.port) == NO_BINDING &&
        $urandom_range(9) < 8)
      front_op(MODE_GRANT, 4'($urandom));
    else if ($urandom_range(3) == 0)
      front_op(MODE_QUERY, 4'($urandom));
    front_op(MODE_POP, 4'($urandom));
  endtask

  // one well-formed packet, pushed flit by flit while the front is served
  task automatic send_packet();
    logic [PID_W-1:0]  pid;
    logic [PORT_W-1:0] port;
    logic [KIND_W-1:0] kind;
    int                flits;
    int                n;
    pid   = pick_pid();
    port  = 3'($urandom_range(7));
    flits = $urandom_range(1, 5);
    for (int k = 0; k < flits; k++) begin
      if (flits == 1)          kind = KIND_HEAD_TAIL;
      else if (k == 0)         kind = KIND_HEAD;
      else if (k == flits - 1) kind = KIND_TAIL;
      else                     kind = KIND_BODY;
      if (fill == DEPTH && $urandom_range(9) != 0) serve_front();
      push_flit(pid, kind, port, $urandom);
      n = $urandom_range(2);
      repeat (n) serve_front();
    end
  endtask

  // arbitrary requests that break packet order
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) send_req(2'($urandom), pick_pid(), 2'($urandom), 3'($urandom), $urandom,
                        4'($urandom));
  endtask

  task automatic test_random_traffic();
    int start;
    start = req_count;
    while (req_count - start < RANDOM_ITEMS) begin
      calm <= (req_count - start >= 500) && (req_count - start < 750);
      if ($urandom_range(99) < 75) send_packet();
      else send_noise();
    end
    calm <= 1'b0;
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // compare each result with the oldest expected report
  always @(posedge clk) begin : check_results
    front_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (resp_count == req_count) begin
        $error("result with no request pending");
        fail_count++;
      end else begin
        want = want_ring[resp_count % RING_SLOTS];
        resp_count++;
        check_field("front_valid", 32'(want.front_valid), 32'(front_valid));
        check_field("front_packet_id", 32'(want.pid), 32'(front_packet_id));
        check_field("front_kind", 32'(want.kind), 32'(front_kind));
        check_field("front_port", 32'(want.port), 32'(front_port));
        check_field("front_handle", want.handle, front_handle);
        check_field("vc_bound", 32'(want.vc_bound), 32'(vc_bound));
        check_field("front_vc", 32'(want.vc), 32'(front_vc));
        check_field("status", 32'(want.status), 32'(status));
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("replica_fifo_with_vc_binding_core_test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    wait_idle();
    test_fifo_full();
    wait_idle();
    test_binding_table_full();
    wait_idle();
    test_random_traffic();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("replica_fifo_with_vc_binding_core_test passed");
    end else begin
      $display("replica_fifo_with_vc_binding_core_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rfvb_pkg.sv
hw/rtl/rfvb_ctrl.sv
hw/rtl/rfvb_dp.sv
hw/rtl/replica_fifo_with_vc_binding_core.sv
verif/replica_fifo_with_vc_binding_core_test.sv
